// ===== rtl/qrv_pkg.sv =====
package qrv_pkg;

  typedef enum logic [1:0] {
    RQ_APPEND  = 2'd0,
    RQ_PREPEND = 2'd1,
    RQ_DEQUEUE = 2'd2,
    RQ_REMOVE  = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DEQ,
    S_SCAN,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [31:0] taken_value;
    status_t     status;
    logic [4:0]  fill_count;
  } res_t;

endpackage

// ===== rtl/qrv_mem.sv =====
module qrv_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/queue_with_remove_by_value_core.sv =====
// An accepted request is registered, then passes through S_START; dequeue adds S_DEQ and
// remove-by-value adds S_SCAN, which walks the held entries; S_FINISH loads the result register.
// Remove scans the held entries once through the RAM read port, closing the gap as it goes.
// One request in flight: a new request is taken only after the result is loaded, which waits
// while a stalled result holds the output register.
// Reset clears the FSM, head pointer, count and output valid; the entry RAM is not cleared.
module queue_with_remove_by_value_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ENTRY_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  qrv_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output qrv_pkg::res_t res
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] a);
    return (a == '0) ? LAST_ADDR : a - 1'b1;
  endfunction

  qrv_pkg::fsm_t    state, state_next;
  qrv_pkg::req_t    cur, cur_next;
  qrv_pkg::status_t status_r, status_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] pos, pos_next;
  logic [PTR_W-1:0] addr, addr_next;
  logic [PTR_W-1:0] prev_addr, prev_next;
  logic             found, found_next;
  logic [ENTRY_BITS-1:0] taken, taken_next;
  logic             res_load;

  logic                  we;
  logic [PTR_W-1:0]      waddr, raddr;
  logic [ENTRY_BITS-1:0] wdata, rdata;
  logic [ENTRY_BITS-1:0] word;
  logic [PTR_W:0]        tail_sum;
  logic [PTR_W-1:0]      tail_addr;
  logic                  last_pos;
  logic                  hit;

  assign req_stall = rst || (state != qrv_pkg::S_IDLE);
  assign word      = ENTRY_BITS'(cur.entry_value);

  // head + count, wrapped once
  assign tail_sum  = {1'b0, head} + (PTR_W + 1)'(count);
  assign tail_addr = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : PTR_W'(tail_sum);
  assign last_pos  = (CNT_W'(pos) + CNT_W'(1)) == count;
  assign hit       = (rdata == word);

  qrv_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ENTRY_BITS),
    .AW   (PTR_W)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    status_next = status_r;
    head_next   = head;
    count_next  = count;
    pos_next    = pos;
    addr_next   = addr;
    prev_next   = prev_addr;
    found_next  = found;
    taken_next  = taken;
    res_load    = 1'b0;
    we          = 1'b0;
    waddr       = addr;
    wdata       = word;
    raddr       = addr;
    case (state)
      qrv_pkg::S_IDLE: begin
        if (req_valid && !req_stall) begin
          cur_next   = req;
          state_next = qrv_pkg::S_START;
        end
      end
      qrv_pkg::S_START: begin
        taken_next  = '0;
        status_next = qrv_pkg::ST_OK;
        found_next  = 1'b0;
        pos_next    = '0;
        addr_next   = head;
        prev_next   = head;
        raddr       = head;
        state_next  = qrv_pkg::S_FINISH;
        case (cur.req_type)
          qrv_pkg::RQ_APPEND: begin
            if (count == FULL_CNT) begin
              status_next = qrv_pkg::ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = tail_addr;
              count_next = count + 1'b1;
            end
          end
          qrv_pkg::RQ_PREPEND: begin
            if (count == FULL_CNT) begin
              status_next = qrv_pkg::ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = wrap_dec(head);
              head_next  = wrap_dec(head);
              count_next = count + 1'b1;
            end
          end
          qrv_pkg::RQ_DEQUEUE: begin
            if (count == '0) begin
              status_next = qrv_pkg::ST_EMPTY;
            end else begin
              state_next = qrv_pkg::S_DEQ;
            end
          end
          qrv_pkg::RQ_REMOVE: begin
            if (count == '0) begin
              status_next = qrv_pkg::ST_EMPTY;
            end else begin
              state_next = qrv_pkg::S_SCAN;
            end
          end
          default: begin
            state_next = qrv_pkg::S_FINISH;
          end
        endcase
      end
      qrv_pkg::S_DEQ: begin
        taken_next = rdata;
        head_next  = wrap_inc(head);
        count_next = count - 1'b1;
        state_next = qrv_pkg::S_FINISH;
      end
      qrv_pkg::S_SCAN: begin
        // rdata holds position pos; fetch pos+1 while deciding on pos
        raddr     = wrap_inc(addr);
        addr_next = wrap_inc(addr);
        prev_next = addr;
        pos_next  = pos + 1'b1;
        if (found) begin
          // past the match: move each entry up one place
          we    = 1'b1;
          waddr = prev_addr;
          wdata = rdata;
        end else if (hit) begin
          found_next = 1'b1;
          taken_next = rdata;
        end
        if (last_pos) begin
          state_next = qrv_pkg::S_FINISH;
          if (found || hit) begin
            count_next = count - 1'b1;
          end else begin
            status_next = qrv_pkg::ST_NOT_FOUND;
          end
        end
      end
      qrv_pkg::S_FINISH: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = qrv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = qrv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qrv_pkg::S_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    status_r  <= status_next;
    pos       <= pos_next;
    addr      <= addr_next;
    prev_addr <= prev_next;
    found     <= found_next;
    taken     <= taken_next;
    if (res_load) begin
      res.taken_value <= 32'(taken);
      res.status      <= status_r;
      res.fill_count  <= 5'(count);
    end
  end

endmodule

// ===== rtl/qrv_check.sv =====
module qrv_check #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input qrv_pkg::req_t req,
  input logic          res_valid,
  input logic          res_stall,
  input qrv_pkg::res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // one request at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != qrv_pkg::ST_OK |-> res.taken_value == '0)
    else $error("failed request returned a value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == qrv_pkg::ST_FULL |-> res.fill_count == 5'(QUEUE_DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == qrv_pkg::ST_EMPTY |-> res.fill_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind queue_with_remove_by_value_core qrv_check #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_check (.*);

// ===== sim/tb_top.sv =====
module tb_top;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 300000;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  qrv_pkg::req_t req       = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  qrv_pkg::res_t res;

  queue_with_remove_by_value_core #(
    .QUEUE_DEPTH(DEPTH),
    .ENTRY_BITS (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #1 clk = ~clk;

  // predicted queue contents, head at index 0
  logic [31:0]   queue_image[$];
  qrv_pkg::res_t pending_results[$];
  logic [31:0]   value_pool[8];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int mismatch_count = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  bit filling        = 1'b1;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic qrv_pkg::res_t apply_request(qrv_pkg::req_t r);
    qrv_pkg::res_t o;
    int            hit;
    o.taken_value = '0;
    o.status      = qrv_pkg::ST_OK;
    hit           = -1;
    case (r.req_type)
      qrv_pkg::RQ_APPEND: begin
        if (queue_image.size() >= DEPTH) o.status = qrv_pkg::ST_FULL;
        else queue_image.push_back(r.entry_value);
      end
      qrv_pkg::RQ_PREPEND: begin
        if (queue_image.size() >= DEPTH) o.status = qrv_pkg::ST_FULL;
        else queue_image.push_front(r.entry_value);
      end
      qrv_pkg::RQ_DEQUEUE: begin
        if (queue_image.size() == 0) o.status = qrv_pkg::ST_EMPTY;
        else o.taken_value = queue_image.pop_front();
      end
      default: begin
        if (queue_image.size() == 0) begin
          o.status = qrv_pkg::ST_EMPTY;
        end else begin
          // first match from the head wins
          for (int i = 0; i < queue_image.size(); i++) begin
            if (hit < 0 && queue_image[i] == r.entry_value) hit = i;
          end
          if (hit < 0) begin
            o.status = qrv_pkg::ST_NOT_FOUND;
          end else begin
            o.taken_value = queue_image[hit];
            queue_image.delete(hit);
          end
        end
      end
    endcase
    o.fill_count = 5'(queue_image.size());
    return o;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at cycle %0d: expected %h, got %h",
               what, cycle_count, want, got);
  endtask

  always @(posedge clk) begin
    qrv_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat (taken_value)", '0, res.taken_value);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        status_hits[res.status]++;
        if (res.taken_value !== want.taken_value)
          report("taken_value", want.taken_value, res.taken_value);
        if (res.status !== want.status)
          report("status", 32'(want.status), 32'(res.status));
        if (res.fill_count !== want.fill_count)
          report("fill_count", 32'(want.fill_count), 32'(res.fill_count));
      end
    end
  end

  // valid stays high between back-to-back beats; it only drops on a gap
  task automatic send_item(qrv_pkg::req_kind_t kind, logic [31:0] value);
    qrv_pkg::req_t item;
    item.req_type    = kind;
    item.entry_value = value;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(apply_request(item));
    sent_count++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 40) return value_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  task automatic test_directed();
    send_item(qrv_pkg::RQ_DEQUEUE, 32'h0);
    send_item(qrv_pkg::RQ_REMOVE, 32'h1234_5678);
    send_item(qrv_pkg::RQ_APPEND, 32'hFFFF_FFFF);
    send_item(qrv_pkg::RQ_PREPEND, 32'h0);
    send_item(qrv_pkg::RQ_APPEND, 32'h5);
    send_item(qrv_pkg::RQ_PREPEND, 32'h5);
    send_item(qrv_pkg::RQ_APPEND, 32'hA5A5_5A5A);
    for (int i = 0; i < 11; i++) begin
      if (i[0]) send_item(qrv_pkg::RQ_PREPEND, 32'h100 + i);
      else send_item(qrv_pkg::RQ_APPEND, 32'h8000_0000 >> i);
    end
    // queue is full now
    send_item(qrv_pkg::RQ_APPEND, 32'hDEAD_BEEF);
    send_item(qrv_pkg::RQ_PREPEND, 32'hDEAD_BEEF);
    send_item(qrv_pkg::RQ_REMOVE, 32'h5);
    send_item(qrv_pkg::RQ_REMOVE, 32'h1234_5678);
    send_item(qrv_pkg::RQ_DEQUEUE, 32'h0);
    send_item(qrv_pkg::RQ_REMOVE, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int n_items);
    int                 roll;
    int                 fill;
    qrv_pkg::req_kind_t kind;
    logic [31:0]        value;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++) begin
      fill = queue_image.size();
      // swing between full and empty, lingering a little at each end
      if (fill == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      if (fill == 0 && $urandom_range(2) == 0) filling = 1'b1;
      roll = $urandom_range(99);
      if (filling) begin
        if (roll < 35) kind = qrv_pkg::RQ_APPEND;
        else if (roll < 65) kind = qrv_pkg::RQ_PREPEND;
        else if (roll < 80) kind = qrv_pkg::RQ_DEQUEUE;
        else kind = qrv_pkg::RQ_REMOVE;
      end else begin
        if (roll < 15) kind = qrv_pkg::RQ_APPEND;
        else if (roll < 25) kind = qrv_pkg::RQ_PREPEND;
        else if (roll < 55) kind = qrv_pkg::RQ_DEQUEUE;
        else kind = qrv_pkg::RQ_REMOVE;
      end
      if (kind == qrv_pkg::RQ_REMOVE && fill != 0 && $urandom_range(99) < 70)
        value = queue_image[$urandom_range(fill - 1)];
      else
        value = pick_value();
      send_item(kind, value);
    end
    wait_drained();
  endtask

  // sender holds off until the block has returned everything
  task automatic test_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    for (int i = 0; i < 3; i++) begin
      wait_drained();
      send_item(qrv_pkg::RQ_PREPEND, pick_value());
      send_item(qrv_pkg::RQ_REMOVE, pick_value());
    end
    wait_drained();
  endtask

  initial begin
    value_pool[0] = 32'h0;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(0, 0, 95);
    test_random(69, 0, 95);
    test_random(0, 69, 95);
    test_random(17, 17, 95);
    test_pause();
    recv_stall_pct = 0;
    repeat (30) @(posedge clk);
    $display("sent %0d requests, checked %0d results over %0d cycles, %0d mismatches",
             sent_count, checked_count, cycle_count, mismatch_count);
    $display("statuses seen: ok %0d, not found %0d, empty %0d, full %0d",
             status_hits[qrv_pkg::ST_OK], status_hits[qrv_pkg::ST_NOT_FOUND],
             status_hits[qrv_pkg::ST_EMPTY], status_hits[qrv_pkg::ST_FULL]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qrv_pkg.sv
rtl/qrv_mem.sv
rtl/queue_with_remove_by_value_core.sv
rtl/qrv_check.sv
sim/tb_top.sv
